[rtl/core/iol_pkg.sv]
// Shared constants, codes and control types for the indexed ordered list.
`timescale 1ns / 1ps
`default_nettype none

package iol_pkg;

  // Storage size and data width of the list.
  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;

  // Field widths of the request.
  localparam int CMD_W = 3;
  localparam int POS_W = 5;

  // Entry count holds 0..CAPACITY; an entry index holds 0..CAPACITY-1.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  // Common width for comparing a position against a count or an index.
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_GET     = 3'd0,
    CMD_SET     = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_REMOVE  = 3'd3,
    CMD_REVERSE = 3'd4
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_REV  = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic rev_step;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic rev_go;
    logic rev_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/iol_ctrl.sv]
// Controller state machine for the indexed ordered list.
`timescale 1ns / 1ps
`default_nettype none

module iol_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire iol_pkg::dp_stat_t stat,
  output iol_pkg::dp_ctrl_t      ctrl
);
  import iol_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // A non-empty reverse only arms the readout counter, so it needs no free slot.
        if (stat.rev_go) begin
          ctrl.exec = 1'b1;
          state_nxt = S_REV;
        end else if (stat.out_free) begin
          ctrl.exec = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REV: begin
        if (stat.out_free) begin
          ctrl.rev_step = 1'b1;
          if (stat.rev_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/iol_datapath.sv]
// Datapath of the indexed ordered list: entry cells, count, readout counter, result register.
`timescale 1ns / 1ps
`default_nettype none

module iol_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire iol_pkg::dp_ctrl_t              ctrl,
  output iol_pkg::dp_stat_t                   stat,
  input  wire logic [iol_pkg::CMD_W-1:0]      in_command,
  input  wire logic [iol_pkg::POS_W-1:0]      in_position,
  input  wire logic [iol_pkg::WORD_WIDTH-1:0] in_word_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [iol_pkg::WORD_WIDTH-1:0]      out_word_out,
  output logic [1:0]                          out_status,
  output logic [iol_pkg::CNT_W-1:0]           out_entry_count,
  output logic                                out_last
);
  import iol_pkg::*;

  // Latched request.
  logic [CMD_W-1:0]      cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [WORD_WIDTH-1:0] word_r;

  // List state.
  logic [WORD_WIDTH-1:0] entries_r [CAPACITY];
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [CNT_W-1:0]      rev_cnt_r;

  // Result register.
  logic                  out_valid_r;
  logic [WORD_WIDTH-1:0] out_word_r;
  stat_t                 out_status_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_last_r;

  // Decode and read signals.
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  in_range;
  logic                  ins_pos_ok;
  logic                  full;
  logic [CNT_W-1:0]      rev_dec;
  logic [IDX_W-1:0]      rd_idx;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [WORD_WIDTH-1:0] res_word;
  stat_t                 res_stat;
  logic                  do_set;
  logic                  do_ins;
  logic                  do_rem;
  logic                  rev_go;
  logic                  res_load;

  // Capture the request on acceptance.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_command;
      pos_r  <= in_position;
      word_r <= in_word_in;
    end
  end

  // Range checks against the current count.
  assign pos_ext    = CMP_W'(pos_r);
  assign cnt_ext    = CMP_W'(count_r);
  assign in_range   = pos_ext < cnt_ext;
  assign ins_pos_ok = pos_ext <= cnt_ext;
  assign full       = count_r == CNT_W'(CAPACITY);

  // Single read port: the addressed entry, or the next one of the reverse readout.
  assign rev_dec = rev_cnt_r - CNT_W'(1);
  assign rd_idx  = ctrl.rev_step ? rev_dec[IDX_W-1:0] : pos_ext[IDX_W-1:0];
  assign rd_word = entries_r[rd_idx];

  // Command decode and result of a single-result command.
  always_comb begin
    res_word = '0;
    res_stat = ST_OK;
    do_set   = 1'b0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    unique case (cmd_r)
      CMD_GET: begin
        if (in_range) begin
          res_word = rd_word;
        end else begin
          res_stat = ST_RANGE;
        end
      end
      CMD_SET: begin
        if (in_range) begin
          do_set = 1'b1;
        end else begin
          res_stat = ST_RANGE;
        end
      end
      CMD_INSERT: begin
        if (!ins_pos_ok) begin
          res_stat = ST_RANGE;
        end else if (full) begin
          res_stat = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (in_range) begin
          res_word = rd_word;
          do_rem   = 1'b1;
        end else begin
          res_stat = ST_RANGE;
        end
      end
      CMD_REVERSE: begin
        // An empty list gives one zero result; otherwise the readout takes over.
      end
      default: begin
        res_stat = ST_RANGE;
      end
    endcase
  end

  assign rev_go   = (cmd_r == CMD_REVERSE) && (count_r != '0);
  assign res_load = ctrl.exec && !rev_go;

  // Count after the command.
  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.exec) begin
      count_r <= count_nxt;
    end
  end

  // Entry cells: each one shifts up, shifts down or takes the new word.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] below;
    logic [WORD_WIDTH-1:0] above;
    logic [CMP_W-1:0]      idx;

    assign idx = CMP_W'(i);

    if (i == 0) begin : g_first
      assign below = word_r;
    end else begin : g_inner_lo
      assign below = entries_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign above = entries_r[i];
    end else begin : g_inner_hi
      assign above = entries_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (ctrl.exec) begin
        if (do_set && (pos_ext == idx)) begin
          entries_r[i] <= word_r;
        end else if (do_ins) begin
          if (pos_ext == idx) begin
            entries_r[i] <= word_r;
          end else if (pos_ext < idx) begin
            entries_r[i] <= below;
          end
        end else if (do_rem && (idx >= pos_ext)) begin
          entries_r[i] <= above;
        end
      end
    end
  end

  // Reverse readout counter: entries still to emit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_cnt_r <= '0;
    end else if (ctrl.exec && rev_go) begin
      rev_cnt_r <= count_r;
    end else if (ctrl.rev_step) begin
      rev_cnt_r <= rev_dec;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load || ctrl.rev_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word_r   <= res_word;
      out_status_r <= res_stat;
      out_count_r  <= count_nxt;
      out_last_r   <= 1'b1;
    end else if (ctrl.rev_step) begin
      out_word_r   <= rd_word;
      out_status_r <= ST_OK;
      out_count_r  <= count_r;
      out_last_r   <= rev_cnt_r == CNT_W'(1);
    end
  end

  // Status to the controller.
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.rev_go   = rev_go;
  assign stat.rev_last = rev_cnt_r == CNT_W'(1);

  assign out_valid       = out_valid_r;
  assign out_word_out    = out_word_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

[rtl/core/indexed_ordered_list.sv]
// Top level of the indexed ordered list: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of CAPACITY words addressed by position. Each request
// carries a command: get, set, insert, remove or reverse readout. Get, set,
// insert and remove pass through two steps: one accepts the request and one
// executes it, in which the entry cells shift up or down in parallel for
// insert and remove; the single result then waits in an output register, so
// the next request can be accepted while it is still stalled. A reverse
// readout emits one entry per cycle while the output is not stalled, through
// the single read port of the entry array, last flagged on entry 0; an empty
// list gives one zero result. Output stalls hold the readout. Every result
// carries the entry count after its command.
module indexed_ordered_list (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [iol_pkg::CMD_W-1:0]      in_command,
  input  wire logic [iol_pkg::POS_W-1:0]      in_position,
  input  wire logic [iol_pkg::WORD_WIDTH-1:0] in_word_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [iol_pkg::WORD_WIDTH-1:0]      out_word_out,
  output logic [1:0]                          out_status,
  output logic [iol_pkg::CNT_W-1:0]           out_entry_count,
  output logic                                out_last
);
  import iol_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequencing of requests.
  iol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Entry storage and result formation.
  iol_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_word_in      (in_word_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word_out    (out_word_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

`ifndef SYNTH
  // The count reported never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  // A full status only appears when the list is at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_entry_count == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

  // A result that is not the last belongs to a readout of a non-empty list.
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> ((out_status == ST_OK) && (out_entry_count != '0)))
    else $error("non-final result outside a reverse readout");

  // An accepted request blocks the next one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in progress");
`endif

endmodule

`default_nettype wire
